/* design/cadm_pkg.sv */
// Shared types, constants and fixed-point helpers of the curvature arcade drive mixer.
package cadm_pkg;

  localparam int unsigned CADM_ROM_DEPTH   = 1024;
  localparam int unsigned CADM_NONLIN_X100 = 50;
  localparam int unsigned CADM_ADDR_W      = 5;
  localparam int unsigned CADM_DATA_W      = 32;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [2:0] {
    REG_DEADBAND     = 3'd0,
    REG_STEP_UP      = 3'd1,
    REG_STEP_DOWN    = 3'd2,
    REG_INERTIA_GAIN = 3'd3,
    REG_TURN_SENS    = 3'd4,
    REG_MIN_SPEED    = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [14:0] dead_zone;
    logic [14:0] slew_step_up;
    logic [14:0] slew_step_down;
    logic [11:0] inertia_gain;
    logic [11:0] turn_sensitivity;
    logic [14:0] min_speed_factor;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROM,
    ST_SUM,
    ST_MUL_SPEED,
    ST_MUL_SENS,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic rom_step;
    logic sum_step;
    logic mul_speed;
    logic mul_sens;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic turn_in_place;
  } dp_status_t;

  function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
    return (a * b) >> 30;
  endfunction

  // Taylor series up to the x^11 term, Q30 in and out, 0 <= x <= pi/2
  function automatic logic [63:0] q30_sin(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    x2 = q30_mul(x, x);
    t  = Q30_ONE;
    t  = Q30_ONE - q30_mul(x2, t) / 64'd110;
    t  = Q30_ONE - q30_mul(x2, t) / 64'd72;
    t  = Q30_ONE - q30_mul(x2, t) / 64'd42;
    t  = Q30_ONE - q30_mul(x2, t) / 64'd20;
    t  = Q30_ONE - q30_mul(x2, t) / 64'd6;
    return q30_mul(x, t);
  endfunction

endpackage

/* design/curvature_arcade_drive_mixer.sv */
// Top level of the curvature arcade drive mixer: register file, controller and datapath.
//
// Curvature ("cheesy") arcade drive mixer. Each request carries a throttle and a
// turn command in signed Q2.14 and returns one forward/turn pair clamped to +-1.0.
// A throttle inside the deadband with a turn outside it turns in place
// (forward 0, turn r*|r| with r the remapped turn); otherwise the throttle is slew
// limited, a negative-inertia accumulator adds the turn change times its gain, and
// the turn is max(|throttle|, min_speed_factor) * (r + acc) * turn_sensitivity.
// Sequencing: a request runs through capture, the registered remap ROM read and the
// sum step, then the speed and sensitivity multiplies unless it turns in place, then
// the final step; no new request is taken before that. The result is valid in the
// cycle after the final step. One shared multiplier forms the inertia, square, speed
// and sensitivity products in turn. The remap ROM holds REMAP_ROM_DEPTH entries computed
// at elaboration, so the block is ready right after reset with no fill pass. A new
// request is taken while a finished result still waits in the output register;
// the final step holds until that register is free. Configuration registers sit
// at byte addresses 0x00..0x14 and must be written only while the block is idle.
module curvature_arcade_drive_mixer #(
  parameter int unsigned REMAP_ROM_DEPTH         = cadm_pkg::CADM_ROM_DEPTH,
  parameter int unsigned REMAP_NONLINEARITY_X100 = cadm_pkg::CADM_NONLIN_X100
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cadm_pkg::CADM_ADDR_W-1:0] paddr,
  input  logic [cadm_pkg::CADM_DATA_W-1:0] pwdata,
  output logic [cadm_pkg::CADM_DATA_W-1:0] prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [15:0]               throttle_cmd,
  input  logic signed [15:0]               turn_cmd,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [15:0]               forward_out,
  output logic signed [15:0]               turn_out
);
  import cadm_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  // Register accesses complete without wait states
  assign pready = 1'b1;

  cadm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // Sequence each request: capture, ROM read, sum, two multiplies unless turning in place, result
  cadm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  cadm_dp #(
    .ROM_DEPTH   (REMAP_ROM_DEPTH),
    .NONLIN_X100 (REMAP_NONLINEARITY_X100)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .status       (status),
    .throttle_cmd (throttle_cmd),
    .turn_cmd     (turn_cmd),
    .forward_out  (forward_out),
    .turn_out     (turn_out)
  );

`ifndef SYNTHESIS
  // Forward result never leaves the +-1.0 range
  a_forward_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (forward_out <= 16'sd16384) && (forward_out >= -16'sd16384))
    else $error("forward_out outside +-1.0");

  // Turn result never leaves the +-1.0 range
  a_turn_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (turn_out <= 16'sd16384) && (turn_out >= -16'sd16384))
    else $error("turn_out outside +-1.0");

  // An accepted request keeps the block busy on the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while previous one still in progress");

  // A result is only produced by a finish step, never while idle
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    (!out_valid && cmd.finish == 1'b0) |=> !out_valid)
    else $error("result appeared without a finish step");
`endif

endmodule

/* design/cadm_regs.sv */
// Configuration register file behind the APB-style port.
module cadm_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cadm_pkg::CADM_ADDR_W-1:0]  paddr,
  input  logic [cadm_pkg::CADM_DATA_W-1:0]  pwdata,
  output logic [cadm_pkg::CADM_DATA_W-1:0]  prdata,
  output cadm_pkg::cfg_t                    cfg
);
  import cadm_pkg::*;

  reg_index_t reg_idx;
  logic       wr_en;

  assign reg_idx = reg_index_t'(paddr[CADM_ADDR_W-1:2]);
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dead_zone        <= 15'd492;
      cfg.slew_step_up     <= 15'd819;
      cfg.slew_step_down   <= 15'd1638;
      cfg.inertia_gain     <= 12'd640;
      cfg.turn_sensitivity <= 12'd384;
      cfg.min_speed_factor <= 15'd8192;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_DEADBAND:     cfg.dead_zone        <= pwdata[14:0];
        REG_STEP_UP:      cfg.slew_step_up     <= pwdata[14:0];
        REG_STEP_DOWN:    cfg.slew_step_down   <= pwdata[14:0];
        REG_INERTIA_GAIN: cfg.inertia_gain     <= pwdata[11:0];
        REG_TURN_SENS:    cfg.turn_sensitivity <= pwdata[11:0];
        REG_MIN_SPEED:    cfg.min_speed_factor <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DEADBAND:     prdata = CADM_DATA_W'(cfg.dead_zone);
      REG_STEP_UP:      prdata = CADM_DATA_W'(cfg.slew_step_up);
      REG_STEP_DOWN:    prdata = CADM_DATA_W'(cfg.slew_step_down);
      REG_INERTIA_GAIN: prdata = CADM_DATA_W'(cfg.inertia_gain);
      REG_TURN_SENS:    prdata = CADM_DATA_W'(cfg.turn_sensitivity);
      REG_MIN_SPEED:    prdata = CADM_DATA_W'(cfg.min_speed_factor);
      default:          prdata = '0;
    endcase
  end

endmodule

/* design/cadm_ctrl.sv */
// Sequencing state machine and output handshake of the drive mixer.
module cadm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  cadm_pkg::dp_status_t status,
  output cadm_pkg::dp_cmd_t    cmd
);
  import cadm_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        out_valid_next;
  logic        slot_free;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (in_valid) state_next = ST_ROM;
      ST_ROM:       state_next = ST_SUM;
      ST_SUM:       state_next = status.turn_in_place ? ST_DONE : ST_MUL_SPEED;
      ST_MUL_SPEED: state_next = ST_MUL_SENS;
      ST_MUL_SENS:  state_next = ST_DONE;
      ST_DONE:      if (slot_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_ROM:       cmd.rom_step  = 1'b1;
      ST_SUM:       cmd.sum_step  = 1'b1;
      ST_MUL_SPEED: cmd.mul_speed = 1'b1;
      ST_MUL_SENS:  cmd.mul_sens  = 1'b1;
      ST_DONE:      cmd.finish    = slot_free;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.finish) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

/* design/cadm_dp.sv */
// Datapath: remap ROM, slew limiter, inertia accumulator and shared multiplier.
module cadm_dp #(
  parameter int unsigned ROM_DEPTH   = cadm_pkg::CADM_ROM_DEPTH,
  parameter int unsigned NONLIN_X100 = cadm_pkg::CADM_NONLIN_X100
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cadm_pkg::cfg_t       cfg,
  input  cadm_pkg::dp_cmd_t    cmd,
  output cadm_pkg::dp_status_t status,
  input  logic signed [15:0]   throttle_cmd,
  input  logic signed [15:0]   turn_cmd,
  output logic signed [15:0]   forward_out,
  output logic signed [15:0]   turn_out
);
  import cadm_pkg::*;

  localparam int unsigned IDX_W = $clog2(ROM_DEPTH);
  localparam logic [63:0] SPAN = (ROM_DEPTH > 1) ? 64'(ROM_DEPTH - 1) : 64'd1;
  localparam logic [63:0] BASE_RAW = HALF_PI_Q30 * 64'(NONLIN_X100) / 64'd100;
  localparam logic [63:0] BASE = (BASE_RAW > HALF_PI_Q30) ? HALF_PI_Q30 : BASE_RAW;
  localparam logic [63:0] DEN = q30_sin(BASE);
  localparam logic [63:0] DEN_SAFE = (DEN == 64'd0) ? 64'd1 : DEN;

  // Double-sine remap curve, evaluated entry by entry at elaboration
  logic [14:0] rom_table [ROM_DEPTH];

  for (genvar gi = 0; gi < ROM_DEPTH; gi++) begin : g_rom
    localparam logic [63:0] XR = Q30_ONE * 64'(gi) / SPAN;
    localparam logic [63:0] X  = (XR > Q30_ONE) ? Q30_ONE : XR;
    localparam logic [63:0] FR = (q30_sin(q30_mul(BASE, X)) << 30) / DEN_SAFE;
    localparam logic [63:0] F  = (FR > Q30_ONE) ? Q30_ONE : FR;
    localparam logic [63:0] GS = (q30_sin(q30_mul(BASE, F)) << 30) / DEN_SAFE;
    localparam logic [63:0] G  = (DEN == 64'd0) ? X : GS;
    localparam logic [63:0] GR = (G + 64'd32768) >> 16;
    localparam logic [14:0] V  = (GR > 64'd16384) ? 15'd16384 : 15'(GR);
    assign rom_table[gi] = V;
  end

  // Architectural state
  logic signed [15:0] last_turn;
  logic signed [15:0] last_throttle;
  logic signed [19:0] inertia_acc;

  // Per-item registers
  logic signed [15:0] turn_q;
  logic               turn_neg_q;
  logic [IDX_W-1:0]   idx_q;
  logic               place_q;
  logic signed [15:0] lin_q;
  logic [14:0]        speed_q;
  logic [15:0]        dmag_q;
  logic               dneg_q;
  logic [14:0]        rom_q;
  logic [47:0]        prod_q;
  logic signed [21:0] sum_q;
  logic [20:0]        rs_mag_q;
  logic               rs_neg_q;

  // Capture-side logic
  logic [15:0]        thr_abs;
  logic [15:0]        turn_abs;
  logic [14:0]        turn_mag;
  logic [IDX_W+15:0]  idx_full;
  logic               place;
  logic signed [17:0] delta;
  logic signed [17:0] step_up_s;
  logic signed [17:0] step_dn_s;
  logic signed [17:0] lin_raw;
  logic signed [15:0] lin;
  logic [14:0]        lin_abs;
  logic [14:0]        speed;
  logic signed [16:0] dturn;
  logic [15:0]        dturn_abs;

  assign thr_abs  = throttle_cmd[15] ? 16'(-throttle_cmd) : 16'(throttle_cmd);
  assign turn_abs = turn_cmd[15] ? 16'(-turn_cmd) : 16'(turn_cmd);
  assign turn_mag = (turn_abs > 16'd16384) ? 15'd16384 : turn_abs[14:0];
  assign idx_full = (IDX_W+16)'(turn_mag) * (IDX_W+16)'(ROM_DEPTH - 1)
                  + (IDX_W+16)'(8192);
  assign place    = (thr_abs < {1'b0, cfg.dead_zone})
                 && (turn_abs > {1'b0, cfg.dead_zone});

  assign delta     = 18'(throttle_cmd) - 18'(last_throttle);
  assign step_up_s = $signed({3'b000, cfg.slew_step_up});
  assign step_dn_s = $signed({3'b000, cfg.slew_step_down});

  always_comb begin
    if (delta > step_up_s) begin
      lin_raw = 18'(last_throttle) + step_up_s;
    end else if (delta < -step_dn_s) begin
      lin_raw = 18'(last_throttle) - step_dn_s;
    end else begin
      lin_raw = 18'(throttle_cmd);
    end
    if (lin_raw > 18'sd16384) begin
      lin = 16'sd16384;
    end else if (lin_raw < -18'sd16384) begin
      lin = -16'sd16384;
    end else begin
      lin = lin_raw[15:0];
    end
  end

  assign lin_abs   = lin[15] ? 15'(-lin) : 15'(lin);
  assign speed     = (lin_abs < cfg.min_speed_factor) ? cfg.min_speed_factor : lin_abs;
  assign dturn     = 17'(turn_cmd) - 17'(last_turn);
  assign dturn_abs = dturn[16] ? 16'(-dturn) : 16'(dturn);

  // Shared multiplier, one product per step
  logic [35:0] mul_a;
  logic [14:0] mul_b;
  logic [50:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.rom_step) begin
      mul_a = 36'(dmag_q);
      mul_b = 15'(cfg.inertia_gain);
    end else if (cmd.sum_step) begin
      mul_a = 36'(rom_q);
      mul_b = rom_q;
    end else if (cmd.mul_speed) begin
      mul_a = 36'(rs_mag_q);
      mul_b = speed_q;
    end else if (cmd.mul_sens) begin
      mul_a = prod_q[35:0];
      mul_b = 15'(cfg.turn_sensitivity);
    end
  end

  assign mul_p = 51'(mul_a) * 51'(mul_b);

  // Inertia sum and remapped turn
  logic [28:0]        term_rnd;
  logic [19:0]        term_mag;
  logic signed [21:0] term;
  logic signed [21:0] sum;
  logic signed [21:0] r_val;
  logic signed [21:0] rs;
  logic [20:0]        rs_mag;

  assign term_rnd = (29'(prod_q[27:0]) + 29'd128) >> 8;
  assign term_mag = term_rnd[19:0];
  assign term     = dneg_q ? -$signed({2'b00, term_mag}) : $signed({2'b00, term_mag});
  assign sum      = 22'(inertia_acc) + term;
  assign r_val    = turn_neg_q ? -$signed({7'b0, rom_q}) : $signed({7'b0, rom_q});
  assign rs       = sum + r_val;
  assign rs_mag   = rs[21] ? 21'(-rs) : 21'(rs);

  // Result scaling and accumulator decay; a full-scale square needs bit 28
  logic [29:0]        sq_rnd;
  logic [47:0]        drv_rnd;
  logic [14:0]        tmag;
  logic               tneg;
  logic signed [15:0] tout;
  logic signed [21:0] decayed;
  logic signed [19:0] acc_next;

  assign sq_rnd  = (30'(prod_q[28:0]) + 30'd8192) >> 14;
  assign drv_rnd = (prod_q + 48'd2097152) >> 22;

  always_comb begin
    if (place_q) begin
      tmag = (sq_rnd > 30'd16384) ? 15'd16384 : sq_rnd[14:0];
      tneg = turn_neg_q;
    end else begin
      tmag = (drv_rnd > 48'd16384) ? 15'd16384 : drv_rnd[14:0];
      tneg = rs_neg_q;
    end
    tout = tneg ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
  end

  always_comb begin
    if (sum_q > 22'sd16384) begin
      decayed = sum_q - 22'sd16384;
    end else if (sum_q < -22'sd16384) begin
      decayed = sum_q + 22'sd16384;
    end else begin
      decayed = '0;
    end
    if (decayed > 22'sd262144) begin
      acc_next = 20'sd262144;
    end else if (decayed < -22'sd262144) begin
      acc_next = -20'sd262144;
    end else begin
      acc_next = decayed[19:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      turn_q     <= turn_cmd;
      turn_neg_q <= turn_cmd[15];
      idx_q      <= idx_full[IDX_W+13:14];
      place_q    <= place;
      lin_q      <= lin;
      speed_q    <= speed;
      dmag_q     <= dturn_abs;
      dneg_q     <= dturn[16];
    end
    if (cmd.rom_step) begin
      rom_q <= rom_table[idx_q];
    end
    if (cmd.rom_step || cmd.sum_step || cmd.mul_speed || cmd.mul_sens) begin
      prod_q <= mul_p[47:0];
    end
    if (cmd.sum_step) begin
      sum_q    <= sum;
      rs_mag_q <= rs_mag;
      rs_neg_q <= rs[21];
    end
    if (cmd.finish) begin
      forward_out <= place_q ? 16'sd0 : lin_q;
      turn_out    <= tout;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_turn     <= '0;
      last_throttle <= '0;
      inertia_acc   <= '0;
    end else if (cmd.finish) begin
      last_turn <= turn_q;
      if (place_q) begin
        last_throttle <= '0;
      end else begin
        last_throttle <= lin_q;
        inertia_acc   <= acc_next;
      end
    end
  end

  assign status.turn_in_place = place_q;

endmodule
